### sv/nps_pkg.sv
// Shared types and constants of the nearest point search block.
// No dependencies; every other file takes its names from here by scope or by import.
package nps_pkg;

   // Coordinate and distance widths
   localparam int COORD_WIDTH = 16;
   localparam int DIST_WIDTH  = 17;

   // Width of |point - query| and of the range check against the distance ceiling
   localparam int ABS_WIDTH = COORD_WIDTH + 1;
   localparam int CMP_WIDTH = (ABS_WIDTH > DIST_WIDTH) ? ABS_WIDTH : DIST_WIDTH;

   // Square root: one extra root bit catches overflow of the distance field
   localparam int ROOT_WIDTH = DIST_WIDTH + 1;
   localparam int SQ_WIDTH   = 2 * ROOT_WIDTH;
   localparam int PROD_WIDTH = 2 * DIST_WIDTH;
   localparam int REM_WIDTH  = ROOT_WIDTH + 3;
   localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH);

   // Configuration port
   localparam int CSR_WIDTH   = (COORD_WIDTH > DIST_WIDTH) ? COORD_WIDTH : DIST_WIDTH;
   localparam int CSR_INDEX_W = 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [DIST_WIDTH-1:0]         dist_type;

   localparam dist_type DIST_MAX    = '1;
   localparam dist_type LIMIT_RESET = DIST_WIDTH'(10000);
   localparam coord_type COORD_NONE = '1;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_QUERY_X        = 2'd0,
      REG_QUERY_Y        = 2'd1,
      REG_DISTANCE_LIMIT = 2'd2
   } csr_index_type;

   // Start of one distance calculation
   typedef struct packed {
      logic      start;
      coord_type point_x;
      coord_type point_y;
      coord_type query_x;
      coord_type query_y;
   } dist_cmd_type;

   // Finished distance
   typedef struct packed {
      logic     done;
      dist_type distance;
   } dist_res_type;

   // Command to the best-point tracker
   typedef struct packed {
      logic      update;
      logic      clear;
      coord_type point_x;
      coord_type point_y;
      dist_type  distance;
      dist_type  limit;
   } track_cmd_type;

   // Best point held so far
   typedef struct packed {
      logic      have_point;
      coord_type x;
      coord_type y;
      dist_type  distance;
   } kept_type;

endpackage

### sv/nps_if.sv
// Handshake channels of the nearest point search block: point words in,
// result words out. Depends on nps_pkg.
interface nps_req_if;
   logic               valid;
   logic               ready;
   nps_pkg::coord_type point_x;
   nps_pkg::coord_type point_y;
   logic               last;

   modport source (output valid, point_x, point_y, last, input ready);
   modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

interface nps_rsp_if;
   logic               valid;
   logic               ready;
   nps_pkg::coord_type best_x;
   nps_pkg::coord_type best_y;
   nps_pkg::dist_type  best_distance;
   logic               found;

   modport source (output valid, best_x, best_y, best_distance, found, input ready);
   modport sink   (input valid, best_x, best_y, best_distance, found, output ready);
endinterface

### sv/nps_dist_unit.sv
// Truncated Euclidean distance: one shared multiplier for the two squares,
// then a digit-by-digit square root, one root bit per cycle. Depends on nps_pkg.
module nps_dist_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  nps_pkg::dist_cmd_type cmd,
   output nps_pkg::dist_res_type res
);

   localparam int AbsW  = nps_pkg::ABS_WIDTH;
   localparam int CmpW  = nps_pkg::CMP_WIDTH;
   localparam int DistW = nps_pkg::DIST_WIDTH;
   localparam int RootW = nps_pkg::ROOT_WIDTH;
   localparam int SqW   = nps_pkg::SQ_WIDTH;
   localparam int ProdW = nps_pkg::PROD_WIDTH;
   localparam int RemW  = nps_pkg::REM_WIDTH;
   localparam int CntW  = nps_pkg::CNT_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQX,
      S_SQY,
      S_ADD,
      S_ROOT
   } state_type;

   state_type           state_ff, state_in;
   logic [DistW-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic                far_ff, far_in;
   logic [ProdW-1:0]    mul_ff, mul_in;
   logic [SqW-1:0]      acc_ff, acc_in;
   logic [RemW-1:0]     rem_ff, rem_in;
   logic [RootW-1:0]    root_ff, root_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                done_ff, done_in;

   logic signed [AbsW-1:0] diff_x, diff_y;
   logic [AbsW-1:0]        abs_x, abs_y;
   logic [CmpW-1:0]        wide_x, wide_y;
   logic [DistW-1:0]       mul_a;
   logic [RemW-1:0]        rem_sh, trial;
   logic                   take;

   // Offsets from the query point and their magnitudes
   always_comb begin
      diff_x = AbsW'(cmd.point_x) - AbsW'(cmd.query_x);
      diff_y = AbsW'(cmd.point_y) - AbsW'(cmd.query_y);
      abs_x  = diff_x[AbsW-1] ? AbsW'(-diff_x) : AbsW'(diff_x);
      abs_y  = diff_y[AbsW-1] ? AbsW'(-diff_y) : AbsW'(diff_y);
      wide_x = CmpW'(abs_x);
      wide_y = CmpW'(abs_y);
   end

   // Shared multiplier operand
   assign mul_a = (state_ff == S_SQX) ? ax_ff : ay_ff;

   // One root digit: bring down two bits, try subtracting 4*root + 1
   always_comb begin
      rem_sh = {rem_ff[RemW-3:0], acc_ff[SqW-1 -: 2]};
      trial  = {{(RemW-RootW-2){1'b0}}, root_ff, 2'b01};
      take   = rem_sh >= trial;
   end

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      far_in   = far_ff;
      mul_in   = mul_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               ax_in    = wide_x[DistW-1:0];
               ay_in    = wide_y[DistW-1:0];
               far_in   = (wide_x > CmpW'(nps_pkg::DIST_MAX))
                       || (wide_y > CmpW'(nps_pkg::DIST_MAX));
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            mul_in   = ProdW'(mul_a) * ProdW'(mul_a);
            state_in = S_SQY;
         end
         S_SQY: begin
            mul_in   = ProdW'(mul_a) * ProdW'(mul_a);
            acc_in   = SqW'(mul_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            acc_in   = acc_ff + SqW'(mul_ff);
            rem_in   = '0;
            root_in  = '0;
            count_in = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            acc_in   = {acc_ff[SqW-3:0], 2'b00};
            rem_in   = take ? rem_sh - trial : rem_sh;
            root_in  = {root_ff[RootW-2:0], take};
            count_in = count_ff + CntW'(1);
            if (count_ff == CntW'(RootW - 1)) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      far_ff   <= far_in;
      mul_ff   <= mul_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
   end

   // Saturate far points and roots beyond the distance field
   assign res.done     = done_ff;
   assign res.distance = (far_ff || root_ff[RootW-1]) ? nps_pkg::DIST_MAX
                                                      : root_ff[DistW-1:0];

endmodule

### sv/nps_tracker.sv
// Best-point register: qualifies each distance against the limit and keeps
// the lexicographic minimum of (distance, x, y). Depends on nps_pkg.
module nps_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  nps_pkg::track_cmd_type cmd,
   output nps_pkg::kept_type      kept
);

   nps_pkg::kept_type kept_ff, kept_in;
   logic              better;

   // Smaller distance wins, then smaller x, then smaller y
   always_comb begin
      if (!kept_ff.have_point) begin
         better = 1'b1;
      end else if (cmd.distance != kept_ff.distance) begin
         better = cmd.distance < kept_ff.distance;
      end else if (cmd.point_x != kept_ff.x) begin
         better = cmd.point_x < kept_ff.x;
      end else begin
         better = cmd.point_y < kept_ff.y;
      end
   end

   always_comb begin
      kept_in = kept_ff;
      if (cmd.clear) begin
         kept_in.have_point = 1'b0;
         kept_in.x          = nps_pkg::COORD_NONE;
         kept_in.y          = nps_pkg::COORD_NONE;
         kept_in.distance   = cmd.limit;
      end else if (cmd.update && (cmd.distance < cmd.limit) && better) begin
         kept_in.have_point = 1'b1;
         kept_in.x          = cmd.point_x;
         kept_in.y          = cmd.point_y;
         kept_in.distance   = cmd.distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff.have_point <= 1'b0;
         kept_ff.x          <= nps_pkg::COORD_NONE;
         kept_ff.y          <= nps_pkg::COORD_NONE;
         kept_ff.distance   <= nps_pkg::LIMIT_RESET;
      end else begin
         kept_ff <= kept_in;
      end
   end

   assign kept = kept_ff;

endmodule

### sv/nearest_point_search_top.sv
// Top level of the nearest point search block.
// Depends on nps_pkg, nps_if, nps_dist_unit and nps_tracker.
//
// Point words arrive on req (point_x, point_y, last) and are compared with
// the query point in the registers query_x, query_y. A point qualifies when
// its truncated Euclidean distance is below distance_limit; the best one
// (smallest distance, then smallest x, then smallest y) is kept. A word
// with last set takes part in the search and then sends one result word on
// rsp: the best point with found set, or (-1,-1), the limit and found clear.
//
// One point is in work at a time. The distance unit forms the two squares
// through its one multiplier and then the square root, one root bit per
// cycle; req stays low until the distance reaches the tracker, so a new
// word is not taken before the previous one is through. A last word then
// holds req low through the emit state, which forms the result word.
// The result sits in an output register; while rsp is stalled the block
// still takes and searches new points, and only waits before it would have
// to overwrite an unread result. Synchronous reset restores query (0,0),
// limit 10000 and an empty search. Registers are to be written through
// csr_write/csr_index/csr_data while idle; the user is bound to this, and
// the block itself does not enforce it.
module nearest_point_search_top (
   input  logic                                clock,
   input  logic                                reset,
   nps_req_if.sink                             req,
   nps_rsp_if.source                           rsp,
   input  logic                                csr_write,
   input  logic [nps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nps_pkg::CSR_WIDTH-1:0]       csr_data
);

   localparam int CoordW = nps_pkg::COORD_WIDTH;
   localparam int DistW  = nps_pkg::DIST_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_EMIT
   } state_type;

   state_type           state_ff, state_in;
   nps_pkg::coord_type  query_x_ff, query_y_ff;
   nps_pkg::dist_type   limit_ff;
   nps_pkg::coord_type  point_x_ff, point_x_in, point_y_ff, point_y_in;
   logic                last_ff, last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   nps_pkg::coord_type  best_x_ff, best_x_in, best_y_ff, best_y_in;
   nps_pkg::dist_type   best_distance_ff, best_distance_in;
   logic                found_ff, found_in;

   nps_pkg::dist_cmd_type  dist_cmd;
   nps_pkg::dist_res_type  dist_res;
   nps_pkg::track_cmd_type track_cmd;
   nps_pkg::kept_type      kept;

   logic req_fire, emit_fire;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
         limit_ff   <= nps_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            nps_pkg::REG_QUERY_X:        query_x_ff <= csr_data[CoordW-1:0];
            nps_pkg::REG_QUERY_Y:        query_y_ff <= csr_data[CoordW-1:0];
            nps_pkg::REG_DISTANCE_LIMIT: limit_ff   <= csr_data[DistW-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign emit_fire = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp.ready);

   // Distance unit
   assign dist_cmd.start   = req_fire;
   assign dist_cmd.point_x = req.point_x;
   assign dist_cmd.point_y = req.point_y;
   assign dist_cmd.query_x = query_x_ff;
   assign dist_cmd.query_y = query_y_ff;

   nps_dist_unit u_dist (
      .clock (clock),
      .reset (reset),
      .cmd   (dist_cmd),
      .res   (dist_res)
   );

   // Best-point tracker
   assign track_cmd.update   = dist_res.done;
   assign track_cmd.clear    = emit_fire;
   assign track_cmd.point_x  = point_x_ff;
   assign track_cmd.point_y  = point_y_ff;
   assign track_cmd.distance = dist_res.distance;
   assign track_cmd.limit    = limit_ff;

   nps_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .cmd   (track_cmd),
      .kept  (kept)
   );

   // Sequencer and result register
   always_comb begin
      state_in         = state_ff;
      point_x_in       = point_x_ff;
      point_y_in       = point_y_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      best_x_in        = best_x_ff;
      best_y_in        = best_y_ff;
      best_distance_in = best_distance_ff;
      found_in         = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               point_x_in = req.point_x;
               point_y_in = req.point_y;
               last_in    = req.last;
               state_in   = S_CALC;
            end
         end
         S_CALC: begin
            if (dist_res.done) begin
               state_in = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in     = 1'b1;
               found_in         = kept.have_point;
               best_x_in        = kept.have_point ? kept.x : nps_pkg::COORD_NONE;
               best_y_in        = kept.have_point ? kept.y : nps_pkg::COORD_NONE;
               best_distance_in = kept.have_point ? kept.distance : limit_ff;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      point_x_ff       <= point_x_in;
      point_y_ff       <= point_y_in;
      last_ff          <= last_in;
      best_x_ff        <= best_x_in;
      best_y_ff        <= best_y_in;
      best_distance_ff <= best_distance_in;
      found_ff         <= found_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.best_x        = best_x_ff;
   assign rsp.best_y        = best_y_ff;
   assign rsp.best_distance = best_distance_ff;
   assign rsp.found         = found_ff;

   // Checks
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      dist_res.done |-> state_ff == S_CALC)
      else $error("distance finished outside a calculation");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req.ready)
      else $error("new point taken while one is in work");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> !kept.have_point && rsp.valid)
      else $error("search not cleared or result lost after emit");

   a_none_marker: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.best_x == nps_pkg::COORD_NONE
                               && rsp.best_y == nps_pkg::COORD_NONE)
      else $error("empty result without the none marker");

endmodule

### test/tb_nearest_point_search_top.sv
// Testbench of nearest_point_search_top: directed and random point sets,
// checked word by word against a predictor of the nearest point search.
// Depends on nps_pkg, nps_if and the block's RTL.
module tb_nearest_point_search_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nps_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   // One expected result word
   typedef struct {
      coord_type best_x;
      coord_type best_y;
      dist_type  best_distance;
      logic      found;
   } nearest_word_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_WIDTH-1:0]   csr_data;

   nps_req_if req_ch ();
   nps_rsp_if rsp_ch ();

   nearest_point_search_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor copy of registers and search state
   coord_type query_x_q, query_y_q;
   dist_type  limit_q;
   coord_type kept_x_q, kept_y_q;
   dist_type  kept_dist_q;
   logic      have_kept_q;

   nearest_word_type expected_nearest[$];
   int  mismatches;
   int  quiet_cycles;
   int  rx_stall_left;
   bit  tx_gaps_on;
   bit  rx_stalls_on;

   always #5 clock = ~clock;

   // Truncated Euclidean distance to the current query
   function automatic dist_type point_distance(coord_type px, coord_type py);
      logic signed [COORD_WIDTH:0] dx, dy;
      longint adx, ady;
      longint unsigned sq, root, trial;
      dx = px - query_x_q;
      dy = py - query_y_q;
      adx = dx;
      ady = dy;
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      sq = adx * adx + ady * ady;
      root = 0;
      for (int b = DIST_WIDTH; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sq) root = trial;
      end
      if (root > DIST_MAX) return DIST_MAX;
      return root[DIST_WIDTH-1:0];
   endfunction

   // Fold one accepted point into the search; a last word queues a result
   task automatic search_point(coord_type px, coord_type py, logic last_flag);
      dist_type d;
      logic better;
      nearest_word_type w;
      d = point_distance(px, py);
      if (d < limit_q) begin
         if (!have_kept_q) better = 1'b1;
         else if (d != kept_dist_q) better = d < kept_dist_q;
         else if (px != kept_x_q) better = px < kept_x_q;
         else better = py < kept_y_q;
         if (better) begin
            kept_x_q    = px;
            kept_y_q    = py;
            kept_dist_q = d;
            have_kept_q = 1'b1;
         end
      end
      if (last_flag) begin
         if (have_kept_q) begin
            w = '{kept_x_q, kept_y_q, kept_dist_q, 1'b1};
         end else begin
            w = '{COORD_NONE, COORD_NONE, limit_q, 1'b0};
         end
         expected_nearest.push_back(w);
         kept_x_q    = COORD_NONE;
         kept_y_q    = COORD_NONE;
         kept_dist_q = limit_q;
         have_kept_q = 1'b0;
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Send one point word; starts and ends at a falling edge
   task automatic send_point(coord_type px, coord_type py, logic last_flag);
      if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.point_x <= px;
      req_ch.point_y <= py;
      req_ch.last    <= last_flag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      search_point(px, py, last_flag);
      @(negedge clock);
   endtask

   // Register write; the predictor follows the same decode
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_WIDTH-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         REG_QUERY_X:        query_x_q = data[COORD_WIDTH-1:0];
         REG_QUERY_Y:        query_y_q = data[COORD_WIDTH-1:0];
         REG_DISTANCE_LIMIT: limit_q   = data[DIST_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bit above a coordinate is don't-care, so it is randomised
   task automatic set_query(coord_type qx, coord_type qy);
      write_reg(REG_QUERY_X, {CSR_WIDTH'($urandom_range(0, 1)) << COORD_WIDTH} | qx);
      write_reg(REG_QUERY_Y, {CSR_WIDTH'($urandom_range(0, 1)) << COORD_WIDTH} | qy);
   endtask

   task automatic set_limit(dist_type lim);
      write_reg(REG_DISTANCE_LIMIT, lim);
   endtask

   // Hold the sender until every result is in, then let the pipe empty
   task automatic drain_and_pause();
      req_ch.valid <= 1'b0;
      while (expected_nearest.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      send_point(16'sd3, 16'sd4, 1'b1);
      send_point(16'sd20000, 16'sd0, 1'b1);
      send_point(-16'sd9999, 16'sd0, 1'b0);
      send_point(16'sd10000, 16'sd0, 1'b1);
   endtask

   task automatic test_ties();
      drain_and_pause();
      set_query(16'sd100, -16'sd200);
      // equal distance: smaller x wins
      send_point(16'sd105, -16'sd200, 1'b0);
      send_point(16'sd95,  -16'sd200, 1'b0);
      send_point(16'sd100, -16'sd195, 1'b0);
      send_point(16'sd103, -16'sd196, 1'b1);
      // equal distance and x: smaller y wins
      send_point(16'sd100, -16'sd195, 1'b0);
      send_point(16'sd100, -16'sd205, 1'b1);
      // tie that only the truncation makes
      send_point(16'sd101, -16'sd199, 1'b0);
      send_point(16'sd101, -16'sd200, 1'b1);
   endtask

   task automatic test_extremes();
      drain_and_pause();
      set_query(-16'sd32768, -16'sd32768);
      set_limit(DIST_MAX);
      send_point(16'sd32767, 16'sd32767, 1'b1);
      send_point(-16'sd32768, -16'sd32768, 1'b0);
      send_point(16'sd32767, -16'sd32768, 1'b1);
      drain_and_pause();
      set_query(16'sd32767, 16'sd32767);
      set_limit('0);
      send_point(16'sd32767, 16'sd32767, 1'b1);
      drain_and_pause();
      set_limit(dist_type'(1));
      send_point(16'sd32767, 16'sd32767, 1'b1);
   endtask

   // A kept point survives a lower limit; later points meet the new one
   task automatic test_limit_mid_scan();
      drain_and_pause();
      set_query(16'sd0, 16'sd0);
      set_limit(dist_type'(50));
      send_point(16'sd30, 16'sd0, 1'b0);
      drain_and_pause();
      set_limit(dist_type'(20));
      send_point(16'sd25, 16'sd0, 1'b1);
      drain_and_pause();
      set_limit(dist_type'(40));
      send_point(16'sd45, 16'sd0, 1'b0);
      drain_and_pause();
      set_limit(dist_type'(60));
      send_point(16'sd50, 16'sd0, 1'b1);
   endtask

   task automatic test_unused_index();
      drain_and_pause();
      write_reg(REG_UNUSED, CSR_WIDTH'($urandom));
      send_point(16'sd7, -16'sd24, 1'b1);
   endtask

   // Random point sets, mostly clustered around the query so ties happen
   task automatic test_random_sets(int item_budget, bit allow_idle);
      int sent, set_len, spread, off_x, off_y;
      coord_type px, py;
      logic last_flag;
      sent = 0;
      while (sent < item_budget) begin
         drain_and_pause();
         case ($urandom_range(0, 4))
            0: set_query($urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff,
                         $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff);
            default: set_query(coord_type'($urandom), coord_type'($urandom));
         endcase
         case ($urandom_range(0, 7))
            0: set_limit('0);
            1: set_limit(DIST_MAX);
            2: set_limit(LIMIT_RESET);
            3: set_limit(dist_type'($urandom_range(1, 300)));
            4: set_limit(dist_type'($urandom_range(0, 131071)));
            default: set_limit(dist_type'($urandom_range(1000, 60000)));
         endcase
         tx_gaps_on   = allow_idle && ($urandom_range(0, 2) != 0);
         rx_stalls_on = allow_idle && ($urandom_range(0, 2) != 0);
         repeat ($urandom_range(8, 20)) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
            case ($urandom_range(0, 4))
               0: spread = 2;
               1: spread = 8;
               2: spread = 60;
               3: spread = 1500;
               default: spread = 30000;
            endcase
            for (int i = 0; i < set_len; i++) begin
               if ($urandom_range(0, 9) < 7) begin
                  off_x = $urandom_range(0, 2 * spread) - spread;
                  off_y = $urandom_range(0, 2 * spread) - spread;
                  px = coord_type'(query_x_q + off_x);
                  py = coord_type'(query_y_q + off_y);
               end else begin
                  px = coord_type'($urandom);
                  py = coord_type'($urandom);
               end
               last_flag = (i == set_len - 1);
               // occasional broken set: early or missing last
               if ($urandom_range(0, 29) == 0) last_flag = 1'($urandom_range(0, 1));
               send_point(px, py, last_flag);
               sent++;
            end
         end
      end
   endtask

   // Result side: random stall bursts while enabled
   always @(negedge clock) begin
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
         rx_stall_left = $urandom_range(1, 14) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      nearest_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_nearest.size() == 0) begin
            report_mismatch("unexpected result word", rsp_ch.best_distance, 0);
         end else begin
            want = expected_nearest.pop_front();
            if (rsp_ch.best_x !== want.best_x)
               report_mismatch("best_x", rsp_ch.best_x, want.best_x);
            if (rsp_ch.best_y !== want.best_y)
               report_mismatch("best_y", rsp_ch.best_y, want.best_y);
            if (rsp_ch.best_distance !== want.best_distance)
               report_mismatch("best_distance", rsp_ch.best_distance, want.best_distance);
            if (rsp_ch.found !== want.found)
               report_mismatch("found", rsp_ch.found, want.found);
         end
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_nearest.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_index      = REG_QUERY_X;
      csr_data       = '0;
      req_ch.valid   = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.last    = 1'b0;
      rsp_ch.ready   = 1'b0;
      rx_stall_left  = 0;
      quiet_cycles   = 0;
      mismatches     = 0;
      tx_gaps_on     = 1'b1;
      rx_stalls_on   = 1'b1;
      query_x_q      = '0;
      query_y_q      = '0;
      limit_q        = LIMIT_RESET;
      kept_x_q       = COORD_NONE;
      kept_y_q       = COORD_NONE;
      kept_dist_q    = LIMIT_RESET;
      have_kept_q    = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_ties();
      test_extremes();
      test_limit_mid_scan();
      test_unused_index();
      test_random_sets(1650, 1'b1);
      test_random_sets(300, 1'b0);

      drain_and_pause();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
